FILE: hdl/ste_pkg.sv
// Shared types and constants for the semaphore table engine.
`default_nettype none

package ste_pkg;

	localparam int NUM_SEMS    = 32;
	localparam int MAX_WAITERS = 16;
	localparam int PID_BITS    = 8;

	localparam int SEM_IDX_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int DEPTH_W    = $clog2(MAX_WAITERS + 1);
	localparam int STK_DEPTH  = NUM_SEMS * MAX_WAITERS;
	localparam int STK_ADDR_W = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;

	localparam logic signed [15:0] CNT_MIN = 16'sh8000;
	localparam logic signed [15:0] CNT_MAX = 16'sh7FFF;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_WAIT    = 2'd2,
		OP_SIGNAL  = 2'd3
	} ste_op_t;

	typedef struct packed {
		ste_op_t           opcode;
		logic [4:0]        sem_id;
		logic signed [15:0] init_value;
		logic [7:0]        caller_pid;
	} ste_cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] granted_id;
		logic       must_block;
		logic       woken_valid;
		logic [7:0] woken_pid;
		logic       last;
	} ste_rsp_t;

	typedef struct packed {
		logic signed [15:0] count;
		logic [DEPTH_W-1:0] depth;
	} ste_meta_t;

	typedef struct packed {
		logic                 set;
		logic                 clr;
		logic [SEM_IDX_W-1:0] idx;
	} ste_slot_op_t;

	typedef struct packed {
		logic                 found;
		logic [SEM_IDX_W-1:0] idx;
	} ste_free_t;

endpackage

`default_nettype wire

FILE: hdl/semaphore_table_engine.sv
// Top level of the semaphore table engine: command sequencer and state memories.
//
// A command beat is taken when start is high and busy is low. Allocate and
// release, and any command on a slot id beyond the table, are answered from
// the idle state, and their result appears on rsp with done high in the next
// cycle. Wait and signal read the slot's count and stack depth from the slot
// memory first and answer from the read state; a signal that wakes n waiters
// then pops the waiter stack memory once per cycle and gives n result beats
// on consecutive cycles, with last marking the final beat. Each result beat
// is on rsp for exactly one cycle while done is high and must be captured
// then; there is no way to hold it. No clearing pass follows reset.
`default_nettype none

module semaphore_table_engine
	import ste_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire ste_cmd_t cmd,
	output logic          done,
	output ste_rsp_t      rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_POP
	} state_t;

	state_t                state_q;
	logic                  done_q;
	ste_rsp_t              rsp_q;
	ste_op_t               op_q;
	logic [SEM_IDX_W-1:0]  id_q;
	logic [PID_BITS-1:0]   pid_q;
	logic [DEPTH_W-1:0]    pop_d_q;

	logic                  acc;
	logic                  id_ok;
	logic [SEM_IDX_W-1:0]  id_idx;
	ste_free_t             free;
	ste_slot_op_t          slot_op;

	logic                  meta_we;
	logic [SEM_IDX_W-1:0]  meta_waddr;
	ste_meta_t             meta_wdata;
	logic                  meta_re;
	ste_meta_t             meta_rd;

	logic                  stk_we;
	logic [STK_ADDR_W-1:0] stk_waddr;
	logic                  stk_re;
	logic [STK_ADDR_W-1:0] stk_raddr;
	logic [PID_BITS-1:0]   stk_rd;

	logic signed [15:0]    cnt_dec;
	logic signed [15:0]    cnt_inc;
	logic                  stk_full;
	logic                  do_push;
	logic                  do_pop;

	function automatic logic [STK_ADDR_W-1:0] stk_addr(
		input logic [SEM_IDX_W-1:0] idx,
		input logic [DEPTH_W-1:0]   d
	);
		stk_addr = STK_ADDR_W'(idx * MAX_WAITERS + d);
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign acc    = start && !busy;
	assign id_idx = SEM_IDX_W'(cmd.sem_id);
	assign id_ok  = (32'(cmd.sem_id) < NUM_SEMS);

	assign cnt_dec  = (meta_rd.count != CNT_MIN) ? meta_rd.count - 16'sd1 : meta_rd.count;
	assign cnt_inc  = (meta_rd.count != CNT_MAX) ? meta_rd.count + 16'sd1 : meta_rd.count;
	assign stk_full = (meta_rd.depth >= DEPTH_W'(MAX_WAITERS));
	assign do_push  = (op_q == OP_WAIT) && !stk_full && (cnt_dec < 16'sd0);
	assign do_pop   = (op_q == OP_SIGNAL) && (cnt_inc >= 16'sd0) && (meta_rd.depth != '0);

	always_comb begin
		slot_op     = '0;
		meta_we     = 1'b0;
		meta_waddr  = id_q;
		meta_wdata  = meta_rd;
		meta_re     = 1'b0;
		stk_we      = 1'b0;
		stk_waddr   = stk_addr(id_q, meta_rd.depth);
		stk_re      = 1'b0;
		stk_raddr   = stk_addr(id_q, meta_rd.depth - DEPTH_W'(1));
		case (state_q)
			S_IDLE: begin
				if (acc && id_ok && cmd.opcode == OP_RELEASE) begin
					slot_op.clr = 1'b1;
					slot_op.idx = id_idx;
				end
				if (acc && cmd.opcode == OP_ALLOC && free.found) begin
					slot_op.set      = 1'b1;
					slot_op.idx      = free.idx;
					meta_we          = 1'b1;
					meta_waddr       = free.idx;
					meta_wdata.count = cmd.init_value;
					meta_wdata.depth = '0;
				end
				meta_re = acc && id_ok && (cmd.opcode == OP_WAIT || cmd.opcode == OP_SIGNAL);
			end
			S_READ: begin
				if (op_q == OP_WAIT) begin
					meta_we          = !stk_full;
					meta_wdata.count = cnt_dec;
					meta_wdata.depth = do_push ? meta_rd.depth + DEPTH_W'(1) : meta_rd.depth;
					stk_we           = do_push;
				end else begin
					meta_we          = 1'b1;
					meta_wdata.count = cnt_inc;
					meta_wdata.depth = do_pop ? '0 : meta_rd.depth;
					stk_re           = do_pop;
				end
			end
			S_POP: begin
				stk_re    = (pop_d_q != '0);
				stk_raddr = stk_addr(id_q, pop_d_q - DEPTH_W'(1));
			end
			default: begin
				meta_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			op_q  <= cmd.opcode;
			id_q  <= id_idx;
			pid_q <= PID_BITS'(cmd.caller_pid);
		end
		if (state_q == S_READ) begin
			pop_d_q <= meta_rd.depth - DEPTH_W'(1);
		end else if (state_q == S_POP && pop_d_q != '0) begin
			pop_d_q <= pop_d_q - DEPTH_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						rsp_q      <= '0;
						rsp_q.last <= 1'b1;
						if (cmd.opcode == OP_ALLOC) begin
							done_q <= 1'b1;
							if (free.found) begin
								rsp_q.granted_id <= 5'(free.idx);
							end else begin
								rsp_q.status <= ST_NO_FREE;
							end
						end else if (!id_ok || cmd.opcode == OP_RELEASE) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (do_pop) begin
						state_q <= S_POP;
					end else begin
						state_q          <= S_IDLE;
						done_q           <= 1'b1;
						rsp_q.status     <= (op_q == OP_WAIT && stk_full) ? ST_FULL : ST_OK;
						rsp_q.must_block <= do_push;
					end
				end
				S_POP: begin
					done_q            <= 1'b1;
					rsp_q             <= '0;
					rsp_q.woken_valid <= 1'b1;
					rsp_q.woken_pid   <= 8'(stk_rd);
					rsp_q.last        <= (pop_d_q == '0);
					if (pop_d_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ste_alloc u_alloc (
		.clk     (clk),
		.arst_n  (arst_n),
		.slot_op (slot_op),
		.free    (free)
	);

	ste_ram #(
		.WIDTH ($bits(ste_meta_t)),
		.DEPTH (NUM_SEMS)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (id_idx),
		.rdata (meta_rd)
	);

	ste_ram #(
		.WIDTH (PID_BITS),
		.DEPTH (STK_DEPTH)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (pid_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	a_alloc_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == OP_ALLOC |=> done && rsp.last)
		else $error("allocate beat did not finish in one cycle");

	a_wait_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == OP_WAIT && id_ok |=> !done ##1 done && rsp.last)
		else $error("wait beat did not finish in two cycles");

	a_pops_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.last |=> done && rsp.woken_valid)
		else $error("woken beats not contiguous");

	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP && pop_d_q != '0 |=> busy)
		else $error("engine released before last pop");

	a_block_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.must_block |-> rsp.status == ST_OK && !rsp.woken_valid)
		else $error("blocked caller with bad status");

endmodule

`default_nettype wire

FILE: hdl/ste_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module ste_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ste_alloc.sv
// Slot in-use flags and lowest-free-slot finder.
`default_nettype none

module ste_alloc
	import ste_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ste_slot_op_t slot_op,
	output ste_free_t         free
);

	logic [NUM_SEMS-1:0] in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (slot_op.set) begin
			in_use_q[slot_op.idx] <= 1'b1;
		end else if (slot_op.clr) begin
			in_use_q[slot_op.idx] <= 1'b0;
		end
	end

	always_comb begin
		free = '0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free.found = 1'b1;
				free.idx   = SEM_IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/semaphore_table_engine_tb.sv
// Testbench for the semaphore table engine: directed and random commands vs. a predictor.
`timescale 1ns / 100ps
`default_nettype none

module semaphore_table_engine_tb;
	import ste_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ste_cmd_t cmd;
	logic     done;
	ste_rsp_t rsp;

	semaphore_table_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	// predicted semaphore table
	bit                 sem_in_use [NUM_SEMS];
	bit                 sem_written [NUM_SEMS];
	logic signed [15:0] sem_count [NUM_SEMS];
	int                 sem_depth [NUM_SEMS];
	logic [7:0]         sem_waiters [NUM_SEMS][MAX_WAITERS];

	ste_rsp_t pending_rsp[$];
	int       mismatch_cnt = 0;
	bit       start_q = 1'b0;
	bit       burst_mode = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void push_rsp(logic [1:0] status, logic [4:0] gid, logic blk,
			logic wv, logic [7:0] wpid, logic lst);
		ste_rsp_t r;
		r.status      = status;
		r.granted_id  = gid;
		r.must_block  = blk;
		r.woken_valid = wv;
		r.woken_pid   = wpid;
		r.last        = lst;
		pending_rsp.push_back(r);
	endfunction

	function automatic bit free_slot_exists();
		for (int i = 0; i < NUM_SEMS; i++)
			if (!sem_in_use[i]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void apply_sem_cmd(ste_cmd_t c);
		int  id;
		bit  woke;
		id   = c.sem_id;
		woke = 1'b0;
		case (c.opcode)
			OP_ALLOC: begin
				for (int i = 0; i < NUM_SEMS; i++) begin
					if (!sem_in_use[i]) begin
						sem_in_use[i]  = 1'b1;
						sem_written[i] = 1'b1;
						sem_count[i]   = c.init_value;
						sem_depth[i]   = 0;
						push_rsp(ST_OK, 5'(i), 1'b0, 1'b0, 8'd0, 1'b1);
						return;
					end
				end
				push_rsp(ST_NO_FREE, 5'd0, 1'b0, 1'b0, 8'd0, 1'b1);
			end
			OP_RELEASE: begin
				sem_in_use[id] = 1'b0;
				push_rsp(ST_OK, 5'd0, 1'b0, 1'b0, 8'd0, 1'b1);
			end
			OP_WAIT: begin
				if (sem_depth[id] >= MAX_WAITERS) begin
					push_rsp(ST_FULL, 5'd0, 1'b0, 1'b0, 8'd0, 1'b1);
				end else begin
					if (sem_count[id] != CNT_MIN) sem_count[id] = sem_count[id] - 16'sd1;
					if (sem_count[id] < 0) begin
						sem_waiters[id][sem_depth[id]] = c.caller_pid;
						sem_depth[id]++;
						push_rsp(ST_OK, 5'd0, 1'b1, 1'b0, 8'd0, 1'b1);
					end else begin
						push_rsp(ST_OK, 5'd0, 1'b0, 1'b0, 8'd0, 1'b1);
					end
				end
			end
			OP_SIGNAL: begin
				if (sem_count[id] != CNT_MAX) sem_count[id] = sem_count[id] + 16'sd1;
				if (sem_count[id] >= 0) begin
					while (sem_depth[id] > 0) begin
						sem_depth[id]--;
						push_rsp(ST_OK, 5'd0, 1'b0, 1'b1, sem_waiters[id][sem_depth[id]],
							sem_depth[id] == 0);
						woke = 1'b1;
					end
				end
				if (!woke) push_rsp(ST_OK, 5'd0, 1'b0, 1'b0, 8'd0, 1'b1);
			end
			default: begin
				$error("unknown opcode %0d", c.opcode);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		ste_rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("result beat with nothing pending: %p", rsp);
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("granted_id", want.granted_id, rsp.granted_id);
				check_field("must_block", want.must_block, rsp.must_block);
				check_field("woken_valid", want.woken_valid, rsp.woken_valid);
				check_field("woken_pid", want.woken_pid, rsp.woken_pid);
				check_field("last", want.last, rsp.last);
			end
		end
	end

	function automatic int idle_gap();
		int r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic send_cmd(ste_op_t op, logic [4:0] id, logic signed [15:0] init,
			logic [7:0] pid);
		ste_cmd_t c;
		int       gap;
		c.opcode     = op;
		c.sem_id     = id;
		c.init_value = init;
		c.caller_pid = pid;
		cmd <= c;
		if (!start_q) begin
			start   <= 1'b1;
			start_q = 1'b1;
		end
		do @(posedge clk); while (busy !== 1'b0);
		apply_sem_cmd(c);
		gap = idle_gap();
		if (gap > 0) begin
			start   <= 1'b0;
			start_q = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (start_q) begin
			start   <= 1'b0;
			start_q = 1'b0;
		end
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [4:0] pick_live_slot();
		logic [4:0] id;
		do begin
			id = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
		end while (!sem_written[id]);
		return id;
	endfunction

	task automatic test_directed();
		send_cmd(OP_ALLOC, 5'd0, 16'sh7FFF, 8'h00);
		send_cmd(OP_ALLOC, 5'd31, 16'sh8000, 8'hFF);
		send_cmd(OP_ALLOC, 5'd0, 16'sd0, 8'h00);
		send_cmd(OP_SIGNAL, 5'd0, 16'sd0, 8'h00);
		send_cmd(OP_WAIT, 5'd1, 16'sd0, 8'hFF);
		send_cmd(OP_WAIT, 5'd1, 16'sd0, 8'h00);
		send_cmd(OP_SIGNAL, 5'd1, 16'sd0, 8'h00);
		send_cmd(OP_WAIT, 5'd2, 16'sd0, 8'hA5);
		send_cmd(OP_WAIT, 5'd2, 16'sd0, 8'h5A);
		send_cmd(OP_SIGNAL, 5'd2, 16'sd0, 8'h00);
		send_cmd(OP_SIGNAL, 5'd2, 16'sd0, 8'h00);
		send_cmd(OP_RELEASE, 5'd2, 16'sd0, 8'h00);
		send_cmd(OP_WAIT, 5'd2, 16'sd0, 8'h03);
		send_cmd(OP_SIGNAL, 5'd2, 16'sd0, 8'h00);
		send_cmd(OP_WAIT, 5'd0, 16'sd0, 8'h11);
		send_cmd(OP_RELEASE, 5'd0, 16'sd0, 8'h00);
		send_cmd(OP_ALLOC, 5'd0, 16'sd1, 8'h00);
		send_cmd(OP_WAIT, 5'd0, 16'sd0, 8'h22);
		send_cmd(OP_SIGNAL, 5'd0, 16'sd0, 8'h00);
		wait_idle();
	endtask

	task automatic test_stack_full();
		logic [4:0] slot;
		for (int i = 0; i < NUM_SEMS; i++) begin
			if (!sem_in_use[i]) begin
				slot = 5'(i);
				break;
			end
		end
		send_cmd(OP_ALLOC, 5'($urandom), 16'sd0, 8'($urandom));
		repeat (MAX_WAITERS) send_cmd(OP_WAIT, slot, 16'($urandom), 8'($urandom));
		send_cmd(OP_WAIT, slot, 16'($urandom), 8'($urandom));
		repeat (MAX_WAITERS) send_cmd(OP_SIGNAL, slot, 16'($urandom), 8'($urandom));
		wait_idle();
	endtask

	task automatic test_table_full();
		while (free_slot_exists())
			send_cmd(OP_ALLOC, 5'($urandom), 16'($urandom), 8'($urandom));
		send_cmd(OP_ALLOC, 5'($urandom), 16'($urandom), 8'($urandom));
		send_cmd(OP_WAIT, 5'd31, 16'($urandom), 8'($urandom));
		send_cmd(OP_SIGNAL, 5'd31, 16'($urandom), 8'($urandom));
		send_cmd(OP_RELEASE, 5'd31, 16'($urandom), 8'($urandom));
		send_cmd(OP_RELEASE, 5'd0, 16'($urandom), 8'($urandom));
		send_cmd(OP_ALLOC, 5'($urandom), 16'sh8000, 8'($urandom));
		send_cmd(OP_ALLOC, 5'($urandom), 16'sh7FFF, 8'($urandom));
		wait_idle();
	endtask

	task automatic test_random();
		ste_op_t            op;
		logic [4:0]         id;
		logic signed [15:0] init;
		int                 r;
		for (int n = 0; n < 500; n++) begin
			if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) == 0) wait_idle();
			r = $urandom_range(0, 99);
			if (r < 12) op = OP_ALLOC;
			else if (r < 20) op = OP_RELEASE;
			else if (r < 60) op = OP_WAIT;
			else op = OP_SIGNAL;
			if (op == OP_WAIT || op == OP_SIGNAL) id = pick_live_slot();
			else id = 5'($urandom);
			r = $urandom_range(0, 99);
			if (r < 70) init = 16'($signed($urandom_range(0, 8)) - 4);
			else if (r < 90) init = 16'($urandom);
			else if (r < 95) init = CNT_MIN;
			else init = CNT_MAX;
			send_cmd(op, id, init, 8'($urandom));
		end
		burst_mode = 1'b0;
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_full();
		test_table_full();
		test_random();
		repeat (24) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d result beats never arrived", pending_rsp.size());
			mismatch_cnt++;
		end
		if (mismatch_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
